FILE: rtl/dsdp_pkg.sv
package dsdp_pkg;

    // Default number of channel slots in the first-half byte store.
    localparam int DEF_MAX_CHANNELS = 8;

    // Width of one DSD byte.
    localparam int BYTE_W = 8;

    // Width of the channel count register.
    localparam int CFG_W = 4;

    // Width of one DoP word.
    localparam int WORD_W = 32;

    // Width of the channel index that travels with each word.
    localparam int CHIDX_W = 3;

    // DoP markers for even and odd frames.
    localparam logic [BYTE_W-1:0] MARKER_EVEN = 8'h05;
    localparam logic [BYTE_W-1:0] MARKER_ODD  = 8'hFA;

endpackage

FILE: rtl/dsdp_store.sv
module dsdp_store #(
    parameter int MAX_CHANNELS = dsdp_pkg::DEF_MAX_CHANNELS,
    parameter int CH_W         = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
    input  logic                        i_clk,
    input  logic                        i_wr_en,
    input  logic [CH_W-1:0]             i_wr_addr,
    input  logic [dsdp_pkg::BYTE_W-1:0] i_wr_data,
    input  logic [CH_W-1:0]             i_rd_addr,
    output logic [dsdp_pkg::BYTE_W-1:0] o_rd_data
);

    // One first-half byte per channel; contents are undefined until written.
    logic [dsdp_pkg::BYTE_W-1:0] r_bytes [MAX_CHANNELS];
    logic [dsdp_pkg::BYTE_W-1:0] r_rd_data;

    // Write the first-half byte of the addressed channel.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_bytes[i_wr_addr] <= i_wr_data;
        end
    end

    // The read address is the channel of the next cycle, so the registered
    // byte is ready when that channel's second half arrives. A write to the
    // same address in this cycle is passed straight through.
    always_ff @(posedge i_clk) begin
        if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
            r_rd_data <= i_wr_data;
        end else begin
            r_rd_data <= r_bytes[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/dsd_over_pcm_packer.sv
// DSD over PCM packer.
// The slave stream carries one interleaved DSD byte per beat in s_axis_tdata.
// A frame is two bytes per channel: the first channel-count bytes are kept,
// and each byte of the second half yields one DoP word on the master stream.
// The word holds the marker (0x05 on even frames, 0xFA on odd frames) in bits
// 31..24, the kept byte of that channel in 23..16, the new byte in 15..8 and
// zeros below. tuser gives the channel index and tlast marks the word of the
// last channel in a frame; the marker toggles after that word.
// The word of an accepted second-half byte is on the master side in the next
// cycle. One byte is accepted in every cycle unless a pending word is stalled;
// the single output register lets a new byte in whenever it is empty or being taken.
// When the receiver stalls with a word pending, s_axis_tready drops until the
// word is taken.
// The configuration port writes the channel count (1 to 8; zero acts as one,
// larger values saturate to MAX_CHANNELS). A write restarts the frame and
// makes the next frame even. Reset sets the count to two, the frame position
// to zero and the parity to even, and empties the output register.
module dsd_over_pcm_packer #(
    parameter int MAX_CHANNELS = dsdp_pkg::DEF_MAX_CHANNELS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Configuration: channel count.
    input  logic                         i_cfg_wr_en,
    input  logic [dsdp_pkg::CFG_W-1:0]   i_cfg_wr_data,
    // Slave stream.
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    input  logic [dsdp_pkg::BYTE_W-1:0]  i_s_axis_tdata,  // [7:0] dsd_byte
    // Master stream.
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    output logic [dsdp_pkg::WORD_W-1:0]  o_m_axis_tdata,  // [31:0] dop_word
    output logic [dsdp_pkg::CHIDX_W-1:0] o_m_axis_tuser,  // [2:0] channel_index
    output logic                         o_m_axis_tlast   // frame_last
);

    localparam int CH_W     = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int EXT_W    = CH_W + dsdp_pkg::CHIDX_W;
    localparam int RST_LAST = ((MAX_CHANNELS < 2) ? MAX_CHANNELS : 2) - 1;

    // Frame state.
    logic [CH_W-1:0] r_last_ch;
    logic [CH_W-1:0] r_chan;
    logic            r_half;
    logic            r_odd;

    // Output register.
    logic                         r_out_valid;
    logic [dsdp_pkg::WORD_W-1:0]  r_out_word;
    logic [CH_W-1:0]              r_out_chan;
    logic                         r_out_last;

    // Next values.
    logic [CH_W-1:0]              n_last_ch;
    logic [CH_W-1:0]              n_chan;
    logic                         n_half;
    logic                         n_odd;
    logic                         n_out_valid;
    logic [dsdp_pkg::WORD_W-1:0]  n_out_word;
    logic [CH_W-1:0]              n_out_chan;
    logic                         n_out_last;

    logic                         accept;
    logic                         at_last_ch;
    logic [5:0]                   cfg_ext;
    logic [5:0]                   cfg_last;
    logic [dsdp_pkg::BYTE_W-1:0]  kept_byte;
    logic [dsdp_pkg::BYTE_W-1:0]  marker;
    logic [EXT_W-1:0]             chan_ext;

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign at_last_ch      = (r_chan == r_last_ch);
    assign marker          = r_odd ? dsdp_pkg::MARKER_ODD : dsdp_pkg::MARKER_EVEN;

    // Highest channel index for a newly written count, with zero and saturation handled.
    always_comb begin
        cfg_ext = {2'b00, i_cfg_wr_data};
        if (cfg_ext == 6'd0) begin
            cfg_last = 6'd0;
        end else if (cfg_ext > 6'(MAX_CHANNELS)) begin
            cfg_last = 6'(MAX_CHANNELS - 1);
        end else begin
            cfg_last = cfg_ext - 6'd1;
        end
    end

    // First-half bytes are stored by channel and read back in the second half.
    dsdp_store #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .CH_W         (CH_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (accept && !r_half && !i_cfg_wr_en),
        .i_wr_addr (r_chan),
        .i_wr_data (i_s_axis_tdata),
        .i_rd_addr (n_chan),
        .o_rd_data (kept_byte)
    );

    // Next frame position, parity and output register contents.
    always_comb begin
        n_last_ch   = r_last_ch;
        n_chan      = r_chan;
        n_half      = r_half;
        n_odd       = r_odd;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_word  = r_out_word;
        n_out_chan  = r_out_chan;
        n_out_last  = r_out_last;
        if (i_cfg_wr_en) begin
            n_last_ch = cfg_last[CH_W-1:0];
            n_chan    = '0;
            n_half    = 1'b0;
            n_odd     = 1'b0;
        end else if (accept) begin
            if (at_last_ch) begin
                n_chan = '0;
                n_half = !r_half;
                if (r_half) begin
                    n_odd = !r_odd;
                end
            end else begin
                n_chan = r_chan + CH_W'(1);
            end
            if (r_half) begin
                n_out_valid = 1'b1;
                n_out_word  = {marker, kept_byte, i_s_axis_tdata,
                               dsdp_pkg::BYTE_W'(0)};
                n_out_chan  = r_chan;
                n_out_last  = at_last_ch;
            end
        end
    end

    // Frame position, parity and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_ch   <= CH_W'(RST_LAST);
            r_chan      <= '0;
            r_half      <= 1'b0;
            r_odd       <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_word  <= '0;
            r_out_chan  <= '0;
            r_out_last  <= 1'b0;
        end else begin
            r_last_ch   <= n_last_ch;
            r_chan      <= n_chan;
            r_half      <= n_half;
            r_odd       <= n_odd;
            r_out_valid <= n_out_valid;
            r_out_word  <= n_out_word;
            r_out_chan  <= n_out_chan;
            r_out_last  <= n_out_last;
        end
    end

    assign chan_ext        = {{dsdp_pkg::CHIDX_W{1'b0}}, r_out_chan};
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_word;
    assign o_m_axis_tuser  = chan_ext[dsdp_pkg::CHIDX_W-1:0];
    assign o_m_axis_tlast  = r_out_last;

`ifndef NO_ASSERTIONS
    // A count write restarts the frame on the first half of an even frame.
    a_cfg_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_wr_en |=> (r_chan == '0) && !r_half && !r_odd)
        else $error("frame not restarted after count write");

    // The channel counter never passes the last channel.
    a_chan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chan <= r_last_ch)
        else $error("channel counter beyond channel count");

    // The word flagged as frame end belongs to the last channel.
    a_last_chan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_last && !$past(i_cfg_wr_en)) |-> (r_out_chan == r_last_ch))
        else $error("frame end on wrong channel");

    // Completing a frame flips the parity and returns to the first half.
    a_parity_flip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_half && at_last_ch && !i_cfg_wr_en) |=>
            (!r_half && (r_odd != $past(r_odd))))
        else $error("parity not toggled at frame end");
`endif

endmodule
